FILE: sv/btsu_pkg.sv
`timescale 1ns / 1ps
package btsu_pkg;

	localparam logic [2:0] OP_BT  = 3'd0;
	localparam logic [2:0] OP_BTS = 3'd1;
	localparam logic [2:0] OP_BTR = 3'd2;
	localparam logic [2:0] OP_BTC = 3'd3;
	localparam logic [2:0] OP_BSF = 3'd4;
	localparam logic [2:0] OP_BSR = 3'd5;

	localparam int unsigned NUM_GROUPS = 4;
	localparam int unsigned GROUP_BITS = 8;

	typedef struct packed {
		logic [2:0]  op;
		logic        mem;
		logic        a16;
		logic [31:0] val;
		logic [31:0] mask;
		logic [31:0] woff;
		logic [31:0] seg;
		logic [31:0] ea;
	} dec_t;

	typedef struct packed {
		logic [2:0]       op;
		logic             mem;
		logic [31:0]      seg;
		logic [31:0]      off;
		logic             cf;
		logic [31:0]      bitres;
		logic [3:0]       grp_nz;
		logic [3:0][2:0]  grp_lo;
		logic [3:0][2:0]  grp_hi;
	} exe_t;

	typedef struct packed {
		logic [31:0] result_value;
		logic        result_write;
		logic        carry_flag;
		logic        zero_flag;
		logic [31:0] word_address;
	} res_t;

endpackage

FILE: sv/btsu_decode.sv
`timescale 1ns / 1ps
module btsu_decode (
	input  logic                clk,
	input  logic                en,
	input  logic [2:0]          operation,
	input  logic                size32,
	input  logic                mem_form,
	input  logic                index_from_register,
	input  logic                addr16,
	input  logic signed [31:0]  bit_index,
	input  logic [31:0]         operand_value,
	input  logic [31:0]         segment_base,
	input  logic [31:0]         ea_offset,
	output btsu_pkg::dec_t      dec_s1
);

	btsu_pkg::dec_t d;
	logic [31:0]    idx;
	logic [4:0]     pos;
	logic           is_bt;

	always_comb begin
		idx   = bit_index;
		is_bt = (operation <= btsu_pkg::OP_BTC);
		pos   = size32 ? idx[4:0] : {1'b0, idx[3:0]};
		d.op  = operation;
		d.mem = mem_form;
		d.a16 = addr16;
		d.val = size32 ? operand_value : {16'h0000, operand_value[15:0]};
		d.mask = 32'h0000_0001 << pos;
		d.seg = segment_base;
		d.ea  = ea_offset;
		if (mem_form && index_from_register && is_bt) begin
			if (size32)
				d.woff = {{3{idx[31]}}, idx[31:5], 2'b00};
			else
				d.woff = {{19{idx[15]}}, idx[15:4], 1'b0};
		end else begin
			d.woff = 32'h0000_0000;
		end
	end

	always_ff @(posedge clk) begin
		if (en)
			dec_s1 <= d;
	end

endmodule

FILE: sv/btsu_execute.sv
`timescale 1ns / 1ps
module btsu_execute (
	input  logic           clk,
	input  logic           en,
	input  btsu_pkg::dec_t dec_s1,
	output btsu_pkg::exe_t exe_s2
);

	btsu_pkg::exe_t e;
	logic [31:0]    sum;

	always_comb begin
		sum      = dec_s1.ea + dec_s1.woff;
		e.op     = dec_s1.op;
		e.mem    = dec_s1.mem;
		e.seg    = dec_s1.seg;
		e.off    = dec_s1.a16 ? {16'h0000, sum[15:0]} : sum;
		e.cf     = |(dec_s1.val & dec_s1.mask);
		case (dec_s1.op)
			btsu_pkg::OP_BTS: e.bitres = dec_s1.val | dec_s1.mask;
			btsu_pkg::OP_BTR: e.bitres = dec_s1.val & ~dec_s1.mask;
			btsu_pkg::OP_BTC: e.bitres = dec_s1.val ^ dec_s1.mask;
			default:          e.bitres = 32'h0000_0000;
		endcase
		// per-byte lowest and highest set bit
		for (int g = 0; g < btsu_pkg::NUM_GROUPS; g++) begin
			e.grp_nz[g] = |dec_s1.val[g*btsu_pkg::GROUP_BITS +: btsu_pkg::GROUP_BITS];
			e.grp_lo[g] = 3'd0;
			e.grp_hi[g] = 3'd0;
			for (int b = btsu_pkg::GROUP_BITS - 1; b >= 0; b--) begin
				if (dec_s1.val[g*btsu_pkg::GROUP_BITS + b])
					e.grp_lo[g] = 3'(b);
			end
			for (int b = 0; b < btsu_pkg::GROUP_BITS; b++) begin
				if (dec_s1.val[g*btsu_pkg::GROUP_BITS + b])
					e.grp_hi[g] = 3'(b);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en)
			exe_s2 <= e;
	end

endmodule

FILE: sv/btsu_resolve.sv
`timescale 1ns / 1ps
module btsu_resolve (
	input  logic           clk,
	input  logic           en,
	input  btsu_pkg::exe_t exe_s2,
	output btsu_pkg::res_t res_s3
);

	btsu_pkg::res_t r;
	logic [1:0]     lo_g;
	logic [1:0]     hi_g;
	logic           zero;

	always_comb begin
		lo_g = 2'd0;
		hi_g = 2'd0;
		for (int g = btsu_pkg::NUM_GROUPS - 1; g >= 0; g--) begin
			if (exe_s2.grp_nz[g])
				lo_g = 2'(g);
		end
		for (int g = 0; g < btsu_pkg::NUM_GROUPS; g++) begin
			if (exe_s2.grp_nz[g])
				hi_g = 2'(g);
		end
		zero = ~|exe_s2.grp_nz;
		r.word_address = exe_s2.mem ? (exe_s2.seg + exe_s2.off) : 32'h0000_0000;
		r.result_value = 32'h0000_0000;
		r.result_write = 1'b0;
		r.carry_flag   = 1'b0;
		r.zero_flag    = 1'b0;
		case (exe_s2.op)
			btsu_pkg::OP_BT: begin
				r.carry_flag = exe_s2.cf;
			end
			btsu_pkg::OP_BTS, btsu_pkg::OP_BTR, btsu_pkg::OP_BTC: begin
				r.carry_flag   = exe_s2.cf;
				r.result_value = exe_s2.bitres;
				r.result_write = 1'b1;
			end
			btsu_pkg::OP_BSF: begin
				r.zero_flag    = zero;
				r.result_write = ~zero;
				if (!zero)
					r.result_value = {27'd0, lo_g, exe_s2.grp_lo[lo_g]};
			end
			btsu_pkg::OP_BSR: begin
				r.zero_flag    = zero;
				r.result_write = ~zero;
				if (!zero)
					r.result_value = {27'd0, hi_g, exe_s2.grp_hi[hi_g]};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en)
			res_s3 <= r;
	end

endmodule

FILE: sv/bit_test_and_scan_unit.sv
`timescale 1ns / 1ps
// channel   | handshake          | payload
// input     | in_valid, in_stall | operation .. ea_offset
// output    | out_valid, out_stall | result_value .. word_address
//
// three register stages: decode, bit op and offset add, scan merge and address add
// one transaction per cycle unless an output stall holds the pipeline
// arst_n clears the stage valid bits only
// an output stall on a valid output freezes every stage and raises in_stall
module bit_test_and_scan_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [2:0]         operation,
	input  logic               size32,
	input  logic               mem_form,
	input  logic               index_from_register,
	input  logic               addr16,
	input  logic signed [31:0] bit_index,
	input  logic [31:0]        operand_value,
	input  logic [31:0]        segment_base,
	input  logic [31:0]        ea_offset,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [31:0]        result_value,
	output logic               result_write,
	output logic               carry_flag,
	output logic               zero_flag,
	output logic [31:0]        word_address
);

	logic           valid_s1;
	logic           valid_s2;
	logic           valid_s3;
	logic           advance;
	btsu_pkg::dec_t dec_s1;
	btsu_pkg::exe_t exe_s2;
	btsu_pkg::res_t res_s3;

	assign advance  = !valid_s3 || !out_stall;
	assign in_stall = !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	btsu_decode u_decode (
		.clk                 (clk),
		.en                  (advance),
		.operation           (operation),
		.size32              (size32),
		.mem_form            (mem_form),
		.index_from_register (index_from_register),
		.addr16              (addr16),
		.bit_index           (bit_index),
		.operand_value       (operand_value),
		.segment_base        (segment_base),
		.ea_offset           (ea_offset),
		.dec_s1              (dec_s1)
	);

	btsu_execute u_execute (
		.clk    (clk),
		.en     (advance),
		.dec_s1 (dec_s1),
		.exe_s2 (exe_s2)
	);

	btsu_resolve u_resolve (
		.clk    (clk),
		.en     (advance),
		.exe_s2 (exe_s2),
		.res_s3 (res_s3)
	);

	assign out_valid    = valid_s3;
	assign result_value = res_s3.result_value;
	assign result_write = res_s3.result_write;
	assign carry_flag   = res_s3.carry_flag;
	assign zero_flag    = res_s3.zero_flag;
	assign word_address = res_s3.word_address;

`ifndef ASSERT_OFF
	a_stall_source: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled without a held output transaction");

	a_zero_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && zero_flag) |-> (!result_write && result_value == 32'h0000_0000))
		else $error("zero scan result written");

	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(carry_flag && zero_flag))
		else $error("carry and zero flags both set");
`endif

endmodule
